>>> rtl/dfbm_pkg.sv
// Shared types, constants and the microcode program of the dual formant bandpass mixer.
package dfbm_pkg;

  localparam int DefSampleBits   = 16;
  localparam int DefCoefFracBits = 22;

  localparam int HistFrac   = 8;
  localparam int WeightFrac = 16;
  localparam int WeightW    = WeightFrac + 1;
  localparam int B0W        = 23;
  localparam int CoefW      = 24;
  localparam int CwW        = 2 * WeightFrac + 1;
  localparam int MulBW      = CwW + 1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegLowB0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLowA1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowA2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHighB0  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHighA1  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHighA2  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDry     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBalance = 3'd7;

  localparam logic [WeightW-1:0] WeightOne = 17'h10000;

  localparam logic [B0W-1:0]          RstLowB0   = 23'd17076;
  localparam logic signed [CoefW-1:0] RstLowA1   = -24'sd8336560;
  localparam logic signed [CoefW-1:0] RstLowA2   = 24'sd4160153;
  localparam logic [B0W-1:0]          RstHighB0  = 23'd40518;
  localparam logic signed [CoefW-1:0] RstHighA1  = -24'sd8147943;
  localparam logic signed [CoefW-1:0] RstHighA2  = 24'sd4113270;
  localparam logic [WeightW-1:0]      RstDry     = 17'd19661;
  localparam logic [WeightW-1:0]      RstBalance = 17'd39322;

  localparam int PcW     = 4;
  localparam int ProgLen = 14;

  typedef enum logic [3:0] {
    A_XD, A_YL1, A_YL2, A_YH1, A_YH2, A_W, A_NW, A_X, A_FL, A_FH
  } a_sel_e;

  typedef enum logic [3:0] {
    B_B0L, B_A1L, B_A2L, B_B0H, B_A1H, B_A2H, B_ND, B_D, B_CW1, B_CW2
  } b_sel_e;

  typedef enum logic [1:0] {
    BASE_ACC, BASE_RND_F, BASE_RND_M
  } base_e;

  typedef enum logic [1:0] {
    SH_NONE, SH_HIST, SH_MIX
  } shift_e;

  typedef enum logic [1:0] {
    C_NONE, C_NO_IN, C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic             in_rdy;
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    base_e            base;
    logic             add_en;
    logic             neg;
    shift_e           shf;
    logic             st_fl;
    logic             st_fh;
    logic             st_cw1;
    logic             st_cw2;
    logic             fin;
    cond_e            cond;
    logic [PcW-1:0]   tgt;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } stat_t;

  // The product register lags the operand selection by one step, so the
  // accumulator field of a word always consumes the product chosen one word earlier.
  function automatic ctrl_t rom_word(logic [PcW-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      4'd0: begin
        w.in_rdy = 1'b1;
        w.cond   = C_NO_IN;
        w.tgt    = 4'd0;
      end
      4'd1: begin
        w.a_sel = A_XD;  w.b_sel = B_B0L;
      end
      4'd2: begin
        w.a_sel = A_YL1; w.b_sel = B_A1L;
        w.base = BASE_RND_F; w.add_en = 1'b1; w.shf = SH_HIST;
      end
      4'd3: begin
        w.a_sel = A_YL2; w.b_sel = B_A2L;
        w.add_en = 1'b1; w.neg = 1'b1;
      end
      4'd4: begin
        w.a_sel = A_XD;  w.b_sel = B_B0H;
        w.add_en = 1'b1; w.neg = 1'b1;
      end
      4'd5: begin
        w.a_sel = A_YH1; w.b_sel = B_A1H; w.st_fl = 1'b1;
        w.base = BASE_RND_F; w.add_en = 1'b1; w.shf = SH_HIST;
      end
      4'd6: begin
        w.a_sel = A_YH2; w.b_sel = B_A2H;
        w.add_en = 1'b1; w.neg = 1'b1;
      end
      4'd7: begin
        w.a_sel = A_W;   w.b_sel = B_ND;
        w.add_en = 1'b1; w.neg = 1'b1;
      end
      4'd8: begin
        w.a_sel = A_NW;  w.b_sel = B_ND;
        w.st_fh = 1'b1;  w.st_cw1 = 1'b1;
      end
      4'd9: begin
        w.a_sel = A_X;   w.b_sel = B_D; w.st_cw2 = 1'b1;
      end
      4'd10: begin
        w.a_sel = A_FL;  w.b_sel = B_CW1;
        w.base = BASE_RND_M; w.add_en = 1'b1; w.shf = SH_MIX;
      end
      4'd11: begin
        w.a_sel = A_FH;  w.b_sel = B_CW2; w.add_en = 1'b1;
      end
      4'd12: begin
        w.add_en = 1'b1;
      end
      4'd13: begin
        w.fin  = 1'b1;
        w.cond = C_OUT_BUSY;
        w.tgt  = 4'd13;
      end
      default: begin
        w.cond = C_NONE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/dfbm_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module dfbm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfbm_pkg::stat_t     stat_i,
  output dfbm_pkg::ctrl_t     ctrl_o
);
  import dfbm_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ctrl_t          word;
  logic           take;

  assign word   = rom_word(pc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      C_NO_IN:    take = !stat_i.in_valid;
      C_OUT_BUSY: take = stat_i.out_busy;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_d = word.tgt;
    end else if (pc_q == PcW'(ProgLen - 1)) begin
      pc_d = '0;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> rtl/dual_formant_bandpass_mixer_core.sv
// Top level of the dual formant bandpass mixer: configuration, datapath and output register.
//
// One input beat carries a signed sample; it runs through two bandpass biquads
// in parallel, their outputs are blended by a balance weight and mixed with the
// dry sample, and one output beat carries the saturated result.
// Both sample channels use valid and ready. The configuration channel writes one
// register per beat by index and is always ready; write it only while idle.
// All multiplies and accumulations run through one shared multiplier and one accumulator under a
// fourteen-step microcode program, one multiply per step.
// An input beat is taken in the idle step; its output beat is offered once the final step
// has written the output register, and the next input is taken only back in the idle step.
// The finished sample waits in an output register, so the block goes back to idle
// while it is pending; if the receiver stalls, the next sample holds in the final
// step until the output register is free.
// Reset clears the filter histories and the output valid, and loads the default
// coefficients and weights.
module dual_formant_bandpass_mixer_core #(
  parameter int SampleBits   = dfbm_pkg::DefSampleBits,
  parameter int CoefFracBits = dfbm_pkg::DefCoefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SampleBits-1:0]  sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleBits-1:0]  sample_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dfbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dfbm_pkg::CfgDataW-1:0] cfg_data_i
);
  import dfbm_pkg::*;

  localparam int HistBits = SampleBits + HistFrac;
  localparam int MulAW    = (HistBits + 1 > WeightW + 1) ? HistBits + 1 : WeightW + 1;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = HistBits + 34;
  localparam int MixShift = HistFrac + 2 * WeightFrac;

  localparam logic signed [AccW-1:0] RndF = {{(AccW-1){1'b0}}, 1'b1} << (CoefFracBits - 1);
  localparam logic signed [AccW-1:0] RndM = {{(AccW-1){1'b0}}, 1'b1} << (MixShift - 1);

  ctrl_t ctrl;
  stat_t stat;

  logic [B0W-1:0]          low_b0_q, high_b0_q;
  logic signed [CoefW-1:0] low_a1_q, low_a2_q, high_a1_q, high_a2_q;
  logic [WeightW-1:0]      dry_q, bal_q, wclamp;

  logic signed [SampleBits-1:0] x_q, x1_q, x2_q;
  logic signed [HistBits-1:0]   yl1_q, yl2_q, yh1_q, yh2_q, fl_q, fh_q, f_res;
  logic [CwW-1:0]               cw1_q, cw2_q;
  logic signed [SampleBits:0]   xdiff;
  logic [WeightW-1:0]           nd, nw;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q, acc_d, term, shifted, base;

  logic signed [AccW-1:0]       fsh, msh;
  logic                         f_ovf, m_ovf;
  logic signed [SampleBits-1:0] m_res, out_q;
  logic                         out_valid_q, out_busy, fin_go, in_acc;

  dfbm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign out_busy      = out_valid_q && !out_ready_i;
  assign stat.in_valid = in_valid_i;
  assign stat.out_busy = out_busy;
  assign fin_go        = ctrl.fin && !out_busy;
  assign in_ready_o    = ctrl.in_rdy;
  assign in_acc        = in_valid_i && ctrl.in_rdy;
  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_q;
  assign cfg_ready_o   = 1'b1;

  assign wclamp = (cfg_data_i[WeightFrac] && |cfg_data_i[WeightFrac-1:0]) ? WeightOne
                                                                          : cfg_data_i[WeightW-1:0];

  assign xdiff = {x_q[SampleBits-1], x_q} - {x2_q[SampleBits-1], x2_q};
  assign nd    = WeightOne - dry_q;
  assign nw    = WeightOne - bal_q;

  always_comb begin
    case (ctrl.a_sel)
      A_XD:    mul_a = {{(MulAW-SampleBits-1){xdiff[SampleBits]}}, xdiff};
      A_YL1:   mul_a = {{(MulAW-HistBits){yl1_q[HistBits-1]}}, yl1_q};
      A_YL2:   mul_a = {{(MulAW-HistBits){yl2_q[HistBits-1]}}, yl2_q};
      A_YH1:   mul_a = {{(MulAW-HistBits){yh1_q[HistBits-1]}}, yh1_q};
      A_YH2:   mul_a = {{(MulAW-HistBits){yh2_q[HistBits-1]}}, yh2_q};
      A_W:     mul_a = {{(MulAW-WeightW){1'b0}}, bal_q};
      A_NW:    mul_a = {{(MulAW-WeightW){1'b0}}, nw};
      A_X:     mul_a = {{(MulAW-SampleBits){x_q[SampleBits-1]}}, x_q};
      A_FL:    mul_a = {{(MulAW-HistBits){fl_q[HistBits-1]}}, fl_q};
      A_FH:    mul_a = {{(MulAW-HistBits){fh_q[HistBits-1]}}, fh_q};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_B0L:   mul_b = {{(MulBW-B0W){1'b0}}, low_b0_q};
      B_A1L:   mul_b = {{(MulBW-CoefW){low_a1_q[CoefW-1]}}, low_a1_q};
      B_A2L:   mul_b = {{(MulBW-CoefW){low_a2_q[CoefW-1]}}, low_a2_q};
      B_B0H:   mul_b = {{(MulBW-B0W){1'b0}}, high_b0_q};
      B_A1H:   mul_b = {{(MulBW-CoefW){high_a1_q[CoefW-1]}}, high_a1_q};
      B_A2H:   mul_b = {{(MulBW-CoefW){high_a2_q[CoefW-1]}}, high_a2_q};
      B_ND:    mul_b = {{(MulBW-WeightW){1'b0}}, nd};
      B_D:     mul_b = {{(MulBW-WeightW){1'b0}}, dry_q};
      B_CW1:   mul_b = {{(MulBW-CwW){1'b0}}, cw1_q};
      B_CW2:   mul_b = {{(MulBW-CwW){1'b0}}, cw2_q};
      default: mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign term   = prod_q[AccW-1:0];

  always_comb begin
    case (ctrl.shf)
      SH_HIST: shifted = term <<< HistFrac;
      SH_MIX:  shifted = term <<< (HistFrac + WeightFrac);
      default: shifted = term;
    endcase
  end

  always_comb begin
    case (ctrl.base)
      BASE_RND_F: base = RndF;
      BASE_RND_M: base = RndM;
      default:    base = acc_q;
    endcase
  end

  assign acc_d = ctrl.add_en ? (ctrl.neg ? base - shifted : base + shifted) : base;

  assign fsh   = acc_q >>> CoefFracBits;
  assign f_ovf = !(&fsh[AccW-1:HistBits-1] || !(|fsh[AccW-1:HistBits-1]));
  assign f_res = f_ovf ? (fsh[AccW-1] ? {1'b1, {(HistBits-1){1'b0}}}
                                      : {1'b0, {(HistBits-1){1'b1}}})
                       : fsh[HistBits-1:0];

  assign msh   = acc_q >>> MixShift;
  assign m_ovf = !(&msh[AccW-1:SampleBits-1] || !(|msh[AccW-1:SampleBits-1]));
  assign m_res = m_ovf ? (msh[AccW-1] ? {1'b1, {(SampleBits-1){1'b0}}}
                                      : {1'b0, {(SampleBits-1){1'b1}}})
                       : msh[SampleBits-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (in_acc) begin
      x_q <= sample_in_i;
    end
    if (ctrl.st_fl) begin
      fl_q <= f_res;
    end
    if (ctrl.st_fh) begin
      fh_q <= f_res;
    end
    if (ctrl.st_cw1) begin
      cw1_q <= prod_q[CwW-1:0];
    end
    if (ctrl.st_cw2) begin
      cw2_q <= prod_q[CwW-1:0];
    end
    if (fin_go) begin
      out_q <= m_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      x1_q        <= '0;
      x2_q        <= '0;
      yl1_q       <= '0;
      yl2_q       <= '0;
      yh1_q       <= '0;
      yh2_q       <= '0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
        x1_q        <= x_q;
        x2_q        <= x1_q;
        yl1_q       <= fl_q;
        yl2_q       <= yl1_q;
        yh1_q       <= fh_q;
        yh2_q       <= yh1_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_b0_q  <= RstLowB0;
      low_a1_q  <= RstLowA1;
      low_a2_q  <= RstLowA2;
      high_b0_q <= RstHighB0;
      high_a1_q <= RstHighA1;
      high_a2_q <= RstHighA2;
      dry_q     <= RstDry;
      bal_q     <= RstBalance;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLowB0:   low_b0_q  <= cfg_data_i[B0W-1:0];
        RegLowA1:   low_a1_q  <= cfg_data_i[CoefW-1:0];
        RegLowA2:   low_a2_q  <= cfg_data_i[CoefW-1:0];
        RegHighB0:  high_b0_q <= cfg_data_i[B0W-1:0];
        RegHighA1:  high_a1_q <= cfg_data_i[CoefW-1:0];
        RegHighA2:  high_a2_q <= cfg_data_i[CoefW-1:0];
        RegDry:     dry_q     <= wclamp;
        RegBalance: bal_q     <= wclamp;
        default:    dry_q     <= dry_q;
      endcase
    end
  end

endmodule

>>> test/dfbm_mix_checker.sv
// Checker for the dual formant bandpass mixer: predicts each output sample and compares it.
`timescale 1ns / 100ps
module dfbm_mix_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic signed [dfbm_pkg::DefSampleBits-1:0] sample_in_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic signed [dfbm_pkg::DefSampleBits-1:0] sample_out_i,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_i,
  input  logic [dfbm_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [dfbm_pkg::CfgDataW-1:0]           cfg_data_i,
  output int                                      samples_due_o,
  output int                                      mismatch_count_o
);
  import dfbm_pkg::*;

  localparam int     SampleW  = DefSampleBits;
  localparam int     HistW    = DefSampleBits + HistFrac;
  localparam int     MixShift = HistFrac + 2 * WeightFrac;
  localparam longint WOne     = WeightOne;

  logic [B0W-1:0]            formant_b0 [2];
  logic signed [CoefW-1:0]   formant_a1 [2];
  logic signed [CoefW-1:0]   formant_a2 [2];
  logic signed [HistW-1:0]   formant_y  [2][2];
  logic signed [SampleW-1:0] sample_hist [2];
  logic [WeightW-1:0]        dry_weight;
  logic [WeightW-1:0]        balance;
  logic signed [SampleW-1:0] expected_q [$];
  logic signed [SampleW-1:0] expected_sample;
  int                        mismatches;

  function automatic logic [WeightW-1:0] clamp_weight(input logic [WeightW-1:0] v);
    return (v > WeightOne) ? WeightOne : v;
  endfunction

  function automatic longint saturate(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [SampleW-1:0] mix_next(input logic signed [SampleW-1:0] x);
    longint xdiff;
    longint acc;
    longint blend;
    longint dry;
    longint bal;
    longint y [2];
    xdiff = longint'(x) - longint'(sample_hist[1]);
    for (int f = 0; f < 2; f++) begin
      acc = longint'(formant_b0[f]) * xdiff * (longint'(1) << HistFrac)
          - longint'(formant_a1[f]) * longint'(formant_y[f][0])
          - longint'(formant_a2[f]) * longint'(formant_y[f][1])
          + (longint'(1) << (DefCoefFracBits - 1));
      y[f] = saturate(acc >>> DefCoefFracBits, HistW);
      formant_y[f][1] = formant_y[f][0];
      formant_y[f][0] = HistW'(y[f]);
    end
    sample_hist[1] = sample_hist[0];
    sample_hist[0] = x;
    dry = dry_weight;
    bal = balance;
    blend = y[0] * bal + y[1] * (WOne - bal);
    acc = longint'(x) * (longint'(1) << HistFrac) * dry * WOne
        + blend * (WOne - dry)
        + (longint'(1) << (MixShift - 1));
    return SampleW'(saturate(acc >>> MixShift, SampleW));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      formant_b0[0] = RstLowB0;
      formant_a1[0] = RstLowA1;
      formant_a2[0] = RstLowA2;
      formant_b0[1] = RstHighB0;
      formant_a1[1] = RstHighA1;
      formant_a2[1] = RstHighA2;
      dry_weight    = RstDry;
      balance       = RstBalance;
      for (int f = 0; f < 2; f++) begin
        formant_y[f][0] = '0;
        formant_y[f][1] = '0;
        sample_hist[f]  = '0;
      end
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegLowB0:   formant_b0[0] = cfg_data_i[B0W-1:0];
          RegLowA1:   formant_a1[0] = cfg_data_i[CoefW-1:0];
          RegLowA2:   formant_a2[0] = cfg_data_i[CoefW-1:0];
          RegHighB0:  formant_b0[1] = cfg_data_i[B0W-1:0];
          RegHighA1:  formant_a1[1] = cfg_data_i[CoefW-1:0];
          RegHighA2:  formant_a2[1] = cfg_data_i[CoefW-1:0];
          RegDry:     dry_weight    = clamp_weight(cfg_data_i[WeightW-1:0]);
          RegBalance: balance       = clamp_weight(cfg_data_i[WeightW-1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("sample_out: no beat expected, actual %0d", sample_out_i);
          mismatches++;
        end else begin
          expected_sample = expected_q.pop_front();
          if (sample_out_i !== expected_sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   expected_sample, sample_out_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(mix_next(sample_in_i));
      end
    end
    samples_due_o    <= expected_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

>>> test/tb_dual_formant_bandpass_mixer_core.sv
// Testbench top for the dual formant bandpass mixer: drives samples, register writes and output stalls.
`timescale 1ns / 100ps
module tb_dual_formant_bandpass_mixer_core;
  import dfbm_pkg::*;

  localparam int SampleW    = DefSampleBits;
  localparam int PhaseCount = 9;
  localparam int PhaseItems = 150;
  localparam int HoldCycles = 400;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgDataW-1:0]       cfg_data_i;

  int                        samples_due;
  int                        mismatch_count;
  bit                        no_idle = 1'b0;
  bit                        hold_output = 1'b0;
  logic signed [SampleW-1:0] last_sample = '0;

  logic signed [SampleW-1:0] corner_samples [10] = '{
    16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
    16'sh7FFF, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA
  };
  logic signed [SampleW-1:0] overflow_samples [6] = '{
    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh8000
  };
  logic signed [SampleW-1:0] weight_samples [4] = '{
    16'sh8000, 16'sh7FFF, 16'sh3039, 16'shFFFF
  };

  dual_formant_bandpass_mixer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  dfbm_mix_checker u_mix_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_i     (sample_out_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .samples_due_o    (samples_due),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic send_sample(input logic signed [SampleW-1:0] v, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (samples_due != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SampleW-1:0] random_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      last_sample = SampleW'($urandom);
    end else if (pick < 6) begin
      last_sample = SampleW'(int'($urandom_range(0, 512)) - 256);
    end else if (pick == 6) begin
      last_sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end else begin
      last_sample = last_sample + SampleW'(int'($urandom_range(0, 2000)) - 1000);
    end
    return last_sample;
  endfunction

  function automatic logic [CfgDataW-1:0] random_reg(input logic [CfgIdxW-1:0] idx);
    logic [CfgDataW-1:0] nominal;
    int                  pick;
    pick = $urandom_range(0, 7);
    case (idx)
      RegLowB0:  nominal = CfgDataW'(RstLowB0);
      RegLowA1:  nominal = CfgDataW'(RstLowA1);
      RegLowA2:  nominal = CfgDataW'(RstLowA2);
      RegHighB0: nominal = CfgDataW'(RstHighB0);
      RegHighA1: nominal = CfgDataW'(RstHighA1);
      RegHighA2: nominal = CfgDataW'(RstHighA2);
      default:   nominal = '0;
    endcase
    if (idx == RegDry || idx == RegBalance) begin
      case (pick)
        0:       return '0;
        1:       return CfgDataW'(WeightOne);
        2:       return CfgDataW'($urandom_range(32'h10001, 32'h1FFFF));
        3:       return CfgDataW'($urandom);
        default: return CfgDataW'($urandom_range(0, 32'h10000));
      endcase
    end
    case (pick)
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return CfgDataW'($urandom);
      default: return nominal + CfgDataW'($urandom_range(0, 4095)) - CfgDataW'(2048);
    endcase
  endfunction

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_output = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegLowB0;
    cfg_data_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_samples[i]) send_sample(corner_samples[i], 0);
    hold_input();
    wait_drained();

    write_reg(RegLowB0, 24'h7FFFFF);
    write_reg(RegLowA1, 24'h800000);
    write_reg(RegLowA2, 24'h7FFFFF);
    write_reg(RegHighB0, 24'hFFFFFF);
    write_reg(RegHighA1, 24'h7FFFFF);
    write_reg(RegHighA2, 24'h800000);
    write_reg(RegDry, 24'h000000);
    write_reg(RegBalance, 24'h01FFFF);
    foreach (overflow_samples[i]) send_sample(overflow_samples[i], 0);
    hold_input();
    wait_drained();

    write_reg(RegDry, 24'h03FFFF);
    write_reg(RegBalance, 24'h020000);
    foreach (weight_samples[i]) send_sample(weight_samples[i], 0);
    hold_input();
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      no_idle = (p == PhaseCount - 1);
      for (int r = RegLowB0; r <= RegBalance; r++) begin
        write_reg(CfgIdxW'(r), random_reg(CfgIdxW'(r)));
      end
      if (p == 1) hold_output = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 3 && i == PhaseItems / 2) begin
          hold_input();
          wait_drained();
        end
        send_sample(random_sample(),
                    (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
      end
      hold_input();
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && samples_due == 0) begin
      $display("dual_formant_bandpass_mixer_core test passed");
    end else begin
      $display("dual_formant_bandpass_mixer_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dual_formant_bandpass_mixer_core test failed");
    $finish;
  end

endmodule
